// File: rtl/mta_pkg.sv
// ----------------------------------------------------------------------------
// mta_pkg
// Shared types, operation codes and constants for the MAC table with aging.
// ----------------------------------------------------------------------------
package mta_pkg;

    localparam int MAC_W  = 48;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;
    localparam int TO_W   = 16;
    // (65535 + 1) * 1000 fits in 26 bits
    localparam int THR_W  = 26;

    localparam logic [TO_W-1:0] TIMEOUT_RESET = 16'd3000;
    localparam int              US_PER_MS     = 1000;

    typedef logic [MAC_W-1:0] t_word;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_TOUCH = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_AGE   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DUMP  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

    // compare unit modes
    localparam logic CMP_EQ  = 1'b0;
    localparam logic CMP_AGE = 1'b1;

endpackage

// File: rtl/mta_store.sv
// ----------------------------------------------------------------------------
// mta_store
// Entry memory: MAC and last-seen time, one write port, one registered read.
// ----------------------------------------------------------------------------
module mta_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  mta_pkg::t_word      i_wmac,
    input  mta_pkg::t_word      i_wseen,
    input  logic [AW-1:0]       i_raddr,
    output mta_pkg::t_word      o_rmac,
    output mta_pkg::t_word      o_rseen
);

    mta_pkg::t_word r_mac_mem  [DEPTH];
    mta_pkg::t_word r_seen_mem [DEPTH];
    mta_pkg::t_word r_rmac;
    mta_pkg::t_word r_rseen;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mac_mem[i_waddr]  <= i_wmac;
            r_seen_mem[i_waddr] <= i_wseen;
        end
        r_rmac  <= r_mac_mem[i_raddr];
        r_rseen <= r_seen_mem[i_raddr];
    end

    assign o_rmac  = r_rmac;
    assign o_rseen = r_rseen;

endmodule

// File: rtl/mta_cmp.sv
// ----------------------------------------------------------------------------
// mta_cmp
// Shared compare unit: MAC match, or staleness test on the last-seen time.
// ----------------------------------------------------------------------------
module mta_cmp (
    input  logic                         i_mode,
    input  mta_pkg::t_word               i_key,
    input  mta_pkg::t_word               i_stamp,
    input  mta_pkg::t_word               i_rd_mac,
    input  mta_pkg::t_word               i_rd_seen,
    input  logic [mta_pkg::THR_W-1:0]    i_thr,
    output logic                         o_hit
);

    mta_pkg::t_word elapsed;

    // floor(elapsed / 1000) > timeout  <=>  elapsed >= (timeout + 1) * 1000
    assign elapsed = i_stamp - i_rd_seen;

    always_comb begin
        if (i_mode == mta_pkg::CMP_AGE) begin
            o_hit = elapsed >= {{(mta_pkg::MAC_W - mta_pkg::THR_W){1'b0}}, i_thr};
        end else begin
            o_hit = i_rd_mac == i_key;
        end
    end

endmodule

// File: rtl/mac_table_with_aging.sv
// ----------------------------------------------------------------------------
// mac_table_with_aging
// Compacted table of MAC addresses with last-seen times and aging scan.
// ----------------------------------------------------------------------------
// Use: one operation beat enters on i_valid/o_ready (i_func, i_mac,
// i_stamp_us); result beats leave on o_valid/i_ready. Add, touch, query,
// age and undefined codes give one result beat with o_last set; dump gives
// one beat per entry in table order (one beat with o_entry_valid low on an
// empty table), o_last on the final one.
// Scan: a sequencer walks the entry memory, which has one registered read
// port, through one shared compare unit, with a read state and an evaluate
// state per entry visited. Add goes straight to its result beat. Touch and
// query visit entries up to the first match or the last entry; age visits all
// entries. Dump gives each entry's beat after its read and evaluate states.
// o_ready is high only while no operation is in flight; the next operation
// is taken in the cycle after the final result beat. A stalled result beat
// holds until i_ready, and the scan waits with it.
// Reset empties the table (the fill count clears; the memory keeps stale
// data, never read) and sets timeout_ms to 3000. timeout_ms sits at APB
// byte address 0.
// ----------------------------------------------------------------------------
module mac_table_with_aging #(
    parameter int TABLE_DEPTH = 16,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // operation channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [mta_pkg::FUNC_W-1:0]   i_func,
    input  logic [mta_pkg::MAC_W-1:0]    i_mac,
    input  logic [mta_pkg::MAC_W-1:0]    i_stamp_us,
    // result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [mta_pkg::STAT_W-1:0]   o_status,
    output logic                         o_present,
    output logic                         o_entry_valid,
    output logic [mta_pkg::MAC_W-1:0]    o_entry_mac,
    output logic [CW-1:0]                o_entry_count,
    output logic [CW-1:0]                o_removed_count,
    output logic                         o_last,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [mta_pkg::FUNC_W-1:0]   r_func, n_func;
    mta_pkg::t_word               r_key, n_key;
    mta_pkg::t_word               r_stamp, n_stamp;
    logic [mta_pkg::THR_W-1:0]    r_thr, n_thr;
    logic [AW-1:0]                r_idx, n_idx;
    logic [CW-1:0]                r_wr, n_wr;
    logic [CW-1:0]                r_rmv, n_rmv;
    logic [CW-1:0]                r_fill, n_fill;
    logic [mta_pkg::TO_W-1:0]     r_timeout;

    logic [mta_pkg::STAT_W-1:0]   r_status, n_status;
    logic                         r_present, n_present;
    logic                         r_ev, n_ev;
    mta_pkg::t_word               r_emac, n_emac;
    logic [CW-1:0]                r_ocnt, n_ocnt;
    logic [CW-1:0]                r_orem, n_orem;
    logic                         r_last, n_last;

    logic                         we;
    logic [AW-1:0]                waddr;
    mta_pkg::t_word               wmac;
    mta_pkg::t_word               wseen;
    mta_pkg::t_word               rd_mac;
    mta_pkg::t_word               rd_seen;
    logic                         cmp_mode;
    logic                         hit;
    logic                         last_idx;
    logic [mta_pkg::TO_W:0]       to_plus1;
    logic [mta_pkg::THR_W-1:0]    thr_calc;
    logic [CW-1:0]                wr_inc;
    logic [CW-1:0]                rmv_inc;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - mta_pkg::TO_W){1'b0}}, r_timeout} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= mta_pkg::TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_timeout <= pwdata[mta_pkg::TO_W-1:0];
        end
    end

    assign to_plus1 = {1'b0, r_timeout} + {{mta_pkg::TO_W{1'b0}}, 1'b1};
    assign thr_calc = {{(mta_pkg::THR_W - mta_pkg::TO_W - 1){1'b0}}, to_plus1}
                    * mta_pkg::THR_W'(mta_pkg::US_PER_MS);

    // ---------------- datapath units ----------------
    mta_store #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wmac  (wmac),
        .i_wseen (wseen),
        .i_raddr (r_idx),
        .o_rmac  (rd_mac),
        .o_rseen (rd_seen)
    );

    assign cmp_mode = (r_func == mta_pkg::FUNC_AGE) ? mta_pkg::CMP_AGE : mta_pkg::CMP_EQ;

    mta_cmp u_cmp (
        .i_mode    (cmp_mode),
        .i_key     (r_key),
        .i_stamp   (r_stamp),
        .i_rd_mac  (rd_mac),
        .i_rd_seen (rd_seen),
        .i_thr     (r_thr),
        .o_hit     (hit)
    );

    assign last_idx = ({{(CW - AW){1'b0}}, r_idx} == r_fill - CW'(1));
    assign wr_inc   = r_wr + CW'(1);
    assign rmv_inc  = r_rmv + CW'(1);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_key     = r_key;
        n_stamp   = r_stamp;
        n_thr     = r_thr;
        n_idx     = r_idx;
        n_wr      = r_wr;
        n_rmv     = r_rmv;
        n_fill    = r_fill;
        n_status  = r_status;
        n_present = r_present;
        n_ev      = r_ev;
        n_emac    = r_emac;
        n_ocnt    = r_ocnt;
        n_orem    = r_orem;
        n_last    = r_last;
        we        = 1'b0;
        waddr     = r_idx;
        wmac      = rd_mac;
        wseen     = r_stamp;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func    = i_func;
                    n_key     = i_mac;
                    n_stamp   = i_stamp_us;
                    n_thr     = thr_calc;
                    n_idx     = '0;
                    n_wr      = '0;
                    n_rmv     = '0;
                    n_status  = mta_pkg::STAT_OK;
                    n_present = 1'b0;
                    n_ev      = 1'b0;
                    n_emac    = '0;
                    n_ocnt    = r_fill;
                    n_orem    = '0;
                    n_last    = 1'b1;
                    n_state   = S_EMIT;
                    case (i_func)
                        mta_pkg::FUNC_ADD: begin
                            if (r_fill < CW'(TABLE_DEPTH)) begin
                                we     = 1'b1;
                                waddr  = r_fill[AW-1:0];
                                wmac   = i_mac;
                                wseen  = i_stamp_us;
                                n_fill = r_fill + CW'(1);
                                n_ocnt = r_fill + CW'(1);
                            end else begin
                                n_status = mta_pkg::STAT_FULL;
                            end
                        end
                        mta_pkg::FUNC_TOUCH: begin
                            if (r_fill == '0) begin
                                n_status = mta_pkg::STAT_NOTFOUND;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        mta_pkg::FUNC_QUERY,
                        mta_pkg::FUNC_AGE,
                        mta_pkg::FUNC_DUMP: begin
                            if (r_fill != '0) begin
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end

            S_READ: begin
                // read data lands in the store's output register
                n_state = S_EVAL;
            end

            S_EVAL: begin
                case (r_func)
                    mta_pkg::FUNC_TOUCH: begin
                        if (hit) begin
                            we      = 1'b1;
                            waddr   = r_idx;
                            wmac    = rd_mac;
                            wseen   = r_stamp;
                            n_state = S_EMIT;
                        end else if (last_idx) begin
                            n_status = mta_pkg::STAT_NOTFOUND;
                            n_state  = S_EMIT;
                        end else begin
                            n_idx   = r_idx + AW'(1);
                            n_state = S_READ;
                        end
                    end
                    mta_pkg::FUNC_QUERY: begin
                        if (hit) begin
                            n_present = 1'b1;
                            n_state   = S_EMIT;
                        end else if (last_idx) begin
                            n_state = S_EMIT;
                        end else begin
                            n_idx   = r_idx + AW'(1);
                            n_state = S_READ;
                        end
                    end
                    mta_pkg::FUNC_AGE: begin
                        // drop stale entries, slide survivors down
                        if (hit) begin
                            n_rmv = rmv_inc;
                        end else begin
                            we    = 1'b1;
                            waddr = r_wr[AW-1:0];
                            wmac  = rd_mac;
                            wseen = rd_seen;
                            n_wr  = wr_inc;
                        end
                        if (last_idx) begin
                            n_fill  = hit ? r_wr : wr_inc;
                            n_ocnt  = hit ? r_wr : wr_inc;
                            n_orem  = hit ? rmv_inc : r_rmv;
                            n_state = S_EMIT;
                        end else begin
                            n_idx   = r_idx + AW'(1);
                            n_state = S_READ;
                        end
                    end
                    mta_pkg::FUNC_DUMP: begin
                        n_ev    = 1'b1;
                        n_emac  = rd_mac;
                        n_last  = last_idx;
                        n_state = S_EMIT;
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end

            S_EMIT: begin
                if (i_ready) begin
                    if (r_func == mta_pkg::FUNC_DUMP && !r_last) begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_key     <= n_key;
        r_stamp   <= n_stamp;
        r_thr     <= n_thr;
        r_idx     <= n_idx;
        r_wr      <= n_wr;
        r_rmv     <= n_rmv;
        r_status  <= n_status;
        r_present <= n_present;
        r_ev      <= n_ev;
        r_emac    <= n_emac;
        r_ocnt    <= n_ocnt;
        r_orem    <= n_orem;
        r_last    <= n_last;
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = (r_state == S_EMIT);
    assign o_status        = r_status;
    assign o_present       = r_present;
    assign o_entry_valid   = r_ev;
    assign o_entry_mac     = r_emac;
    assign o_entry_count   = r_ocnt;
    assign o_removed_count = r_orem;
    assign o_last          = r_last;

    // ---------------- assertions ----------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("new operation taken while a result beat is pending");

    a_removed_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_removed_count != '0) |-> o_last)
        else $error("aging result not marked last");

    a_dump_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_entry_valid) |-> o_entry_count != '0)
        else $error("dump beat from an empty table");

    a_age_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_func == mta_pkg::FUNC_AGE) |=> r_fill <= $past(r_fill))
        else $error("aging scan grew the table");

endmodule
